[hdl/assert_macros.svh]
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clk edge outside reset
`define PWMR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clk edge, reset included
`define PWMR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/pwmr_pkg.sv]
`default_nettype none
package pwmr_pkg;

  localparam int LEVEL_BITS = 8;
  localparam int SPAN_BITS  = 16;
  localparam int CLOCK_BITS = 32;

  localparam logic FUNC_START  = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  typedef struct packed {
    logic                  func;
    logic [LEVEL_BITS-1:0] target_level;
    logic [SPAN_BITS-1:0]  ramp_time_ms;
    logic [CLOCK_BITS-1:0] now_ms;
  } pwmr_in_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] duty_level;
    logic                  duty_written;
    logic                  ramp_done;
    logic                  ramp_active;
  } pwmr_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ELAPSED,
    S_MULDIV,
    S_APPLY,
    S_EMIT
  } pwmr_state_t;

  typedef struct packed {
    logic el_start;
    logic md_start;
    logic decode;
    logic apply;
    logic emit;
  } pwmr_ctl_t;

endpackage
`default_nettype wire

[hdl/pwmr_elapsed.sv]
`default_nettype none
module pwmr_elapsed
  import pwmr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [CLOCK_BITS-1:0] now_ms,
  input  wire logic [CLOCK_BITS-1:0] begin_ms,
  input  wire logic [SPAN_BITS-1:0]  span_ms,
  output logic                       done,
  output logic [SPAN_BITS-1:0]       elapsed_sat,
  output logic                       ge
);

  localparam int CW = $clog2(CLOCK_BITS);

  logic [CLOCK_BITS-1:0] a_r, b_r, sp_r, e_r;
  logic                  borrow_r, gt_r, eq_r;
  logic                  busy_r, done_r;
  logic [CW-1:0]         cnt_r;

  logic d_bit, s_bit, borrow_nxt, gt_nxt, eq_nxt;

  // lsb-first subtract and compare, one bit a cycle
  always_comb begin
    d_bit      = a_r[0] ^ b_r[0] ^ borrow_r;
    borrow_nxt = (~a_r[0] & b_r[0]) | (~(a_r[0] ^ b_r[0]) & borrow_r);
    s_bit      = sp_r[0];
    gt_nxt     = (d_bit & ~s_bit) | (~(d_bit ^ s_bit) & gt_r);
    eq_nxt     = eq_r & ~(d_bit ^ s_bit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(CLOCK_BITS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r      <= now_ms;
      b_r      <= begin_ms;
      sp_r     <= {{(CLOCK_BITS-SPAN_BITS){1'b0}}, span_ms};
      borrow_r <= 1'b0;
      gt_r     <= 1'b0;
      eq_r     <= 1'b1;
    end else if (busy_r) begin
      a_r      <= a_r >> 1;
      b_r      <= b_r >> 1;
      sp_r     <= sp_r >> 1;
      e_r      <= {d_bit, e_r[CLOCK_BITS-1:1]};
      borrow_r <= borrow_nxt;
      gt_r     <= gt_nxt;
      eq_r     <= eq_nxt;
    end
  end

  assign done        = done_r;
  assign ge          = gt_r | eq_r;
  assign elapsed_sat = gt_r ? span_ms : e_r[SPAN_BITS-1:0];

endmodule
`default_nettype wire

[hdl/pwmr_muldiv.sv]
`default_nettype none
module pwmr_muldiv
  import pwmr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [LEVEL_BITS-1:0] mag,
  input  wire logic [SPAN_BITS-1:0]  mult,
  input  wire logic [SPAN_BITS-1:0]  divisor,
  output logic                       done,
  output logic [LEVEL_BITS-1:0]      quot
);

  localparam int CW = $clog2(LEVEL_BITS);

  logic [SPAN_BITS-1:0]  hi_r;
  logic [LEVEL_BITS-1:0] lo_r;
  logic [CW-1:0]         cnt_r;
  logic                  busy_r, div_phase_r, done_r;

  logic [SPAN_BITS:0] sum, trial, diff;
  logic               qbit;

  always_comb begin
    // shift-add: multiplier bits leave lo at the bottom, product bits enter at the top
    sum   = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mult} : '0);
    // restoring divide: quotient fits lo since elapsed never exceeds the span
    trial = {hi_r, lo_r[LEVEL_BITS-1]};
    diff  = trial - {1'b0, divisor};
    qbit  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      div_phase_r <= 1'b0;
      done_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      done_r <= !start && busy_r && div_phase_r && (cnt_r == '0);
      if (start) begin
        busy_r      <= 1'b1;
        div_phase_r <= 1'b0;
        cnt_r       <= CW'(LEVEL_BITS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          cnt_r <= CW'(LEVEL_BITS - 1);
          if (div_phase_r) begin
            busy_r <= 1'b0;
          end else begin
            div_phase_r <= 1'b1;
          end
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi_r <= '0;
      lo_r <= mag;
    end else if (busy_r) begin
      if (!div_phase_r) begin
        hi_r <= sum[SPAN_BITS:1];
        lo_r <= {sum[0], lo_r[LEVEL_BITS-1:1]};
      end else begin
        hi_r <= qbit ? diff[SPAN_BITS-1:0] : trial[SPAN_BITS-1:0];
        lo_r <= {lo_r[LEVEL_BITS-2:0], qbit};
      end
    end
  end

  assign done = done_r;
  assign quot = lo_r;

endmodule
`default_nettype wire

[hdl/pwm_linear_ramp_core.sv]
// pwm_linear_ramp_core: linear fade of an 8-bit pwm duty level
//
// input channel (in_valid / in_stall / in_data): one transaction per item.
//   func = start latches target, ramp length and start time, unless a ramp
//   is running; func = update carries the millisecond clock and moves the
//   level along the line start + delta * elapsed / span.
// result channel (out_valid / out_stall / out_data): one transaction per
//   item with the duty level, write strobe, done flag and active flag.
// sequence: a start or an idle update goes from decode straight to emit;
//   an update during a ramp runs the 32-bit bit-serial elapsed-time
//   subtract and compare, then the shift-add multiply and the restoring
//   divide, then apply and emit.
//   an update that lands past the end of the ramp skips multiply and divide.
// throughput: one item at a time; in_stall is high from acceptance until
//   the result has been placed in the output register.
// a waiting result in the output register holds while out_stall is high;
//   the next item is accepted meanwhile and waits in the emit step.
// reset (rst_n low, synchronous) clears level, ramp state and flags to zero
// and empties the output register.
`default_nettype none
module pwm_linear_ramp_core
  import pwmr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire pwmr_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output pwmr_out_t      out_data
);

  `include "assert_macros.svh"

  pwmr_state_t state_r, state_nxt;
  pwmr_ctl_t   ctl;

  pwmr_in_t    item_r;
  pwmr_out_t   out_data_r;
  logic        out_valid_r;

  // ramp state
  logic [LEVEL_BITS-1:0]      level_now_r, goal_r, start_r;
  logic signed [LEVEL_BITS:0] delta_r;
  logic [SPAN_BITS-1:0]       span_r;
  logic [CLOCK_BITS-1:0]      start_time_r;
  logic                       active_r, done_r, written_r;

  // serial units
  logic                  el_done, el_ge;
  logic [SPAN_BITS-1:0]  el_sat;
  logic                  md_done;
  logic [LEVEL_BITS-1:0] md_quot;

  logic                       is_update;
  logic signed [LEVEL_BITS:0] delta_neg;
  logic [LEVEL_BITS-1:0]      mag;
  logic signed [LEVEL_BITS+1:0] q_ext, lvl;
  logic [LEVEL_BITS-1:0]      lvl_clamped;

  assign is_update = (item_r.func == FUNC_UPDATE);
  assign in_stall  = (state_r != S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_DECODE;
      S_DECODE:  state_nxt = (is_update && active_r) ? S_ELAPSED : S_EMIT;
      S_ELAPSED: if (el_done) state_nxt = el_ge ? S_APPLY : S_MULDIV;
      S_MULDIV:  if (md_done) state_nxt = S_APPLY;
      S_APPLY:   state_nxt = S_EMIT;
      S_EMIT:    if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // step controls
  always_comb begin
    ctl          = '0;
    ctl.decode   = (state_r == S_DECODE);
    ctl.el_start = (state_r == S_DECODE) && is_update && active_r;
    ctl.md_start = (state_r == S_ELAPSED) && el_done && !el_ge;
    ctl.apply    = (state_r == S_APPLY);
    ctl.emit     = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // item register, loaded on the input transaction
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) item_r <= in_data;
  end

  pwmr_elapsed u_elapsed (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (ctl.el_start),
    .now_ms      (item_r.now_ms),
    .begin_ms    (start_time_r),
    .span_ms     (span_r),
    .done        (el_done),
    .elapsed_sat (el_sat),
    .ge          (el_ge)
  );

  // magnitude of the signed level difference
  assign delta_neg = -delta_r;
  assign mag       = delta_r[LEVEL_BITS] ? delta_neg[LEVEL_BITS-1:0] : delta_r[LEVEL_BITS-1:0];

  pwmr_muldiv u_muldiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (ctl.md_start),
    .mag     (mag),
    .mult    (el_sat),
    .divisor (span_r),
    .done    (md_done),
    .quot    (md_quot)
  );

  // new level: start plus or minus the quotient, clamped to the level range
  always_comb begin
    q_ext = $signed({2'b00, md_quot});
    lvl   = $signed({2'b00, start_r}) + (delta_r[LEVEL_BITS] ? -q_ext : q_ext);
    if (lvl[LEVEL_BITS+1])   lvl_clamped = '0;
    else if (lvl[LEVEL_BITS]) lvl_clamped = '1;
    else                     lvl_clamped = lvl[LEVEL_BITS-1:0];
  end

  // ramp state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_now_r  <= '0;
      goal_r       <= '0;
      start_r      <= '0;
      delta_r      <= '0;
      span_r       <= '0;
      start_time_r <= '0;
      active_r     <= 1'b0;
      done_r       <= 1'b0;
      written_r    <= 1'b0;
    end else if (ctl.decode) begin
      // only an update during a ramp drives the level to the output
      written_r <= is_update && active_r;
      if (!is_update) begin
        if (!active_r) begin
          goal_r <= item_r.target_level;
          if (item_r.target_level != level_now_r) begin
            span_r       <= item_r.ramp_time_ms;
            delta_r      <= $signed({1'b0, item_r.target_level})
                          - $signed({1'b0, level_now_r});
            start_r      <= level_now_r;
            start_time_r <= item_r.now_ms;
            active_r     <= 1'b1;
          end
        end
      end else if (!active_r) begin
        // idle update clears the one-shot done flag
        done_r <= 1'b0;
      end
    end else if (ctl.apply) begin
      // past the end of the span (zero span included), or on reaching the goal, lands on the goal
      if (el_ge || lvl_clamped == goal_r) begin
        level_now_r <= goal_r;
        active_r    <= 1'b0;
        done_r      <= 1'b1;
      end else begin
        level_now_r <= lvl_clamped;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_data_r.duty_level   <= level_now_r;
      out_data_r.duty_written <= written_r;
      out_data_r.ramp_done    <= done_r;
      out_data_r.ramp_active  <= active_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `PWMR_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "accept while busy")
  `PWMR_ASSERT(a_load_from_emit, $rose(out_valid_r) |-> $past(state_r == S_EMIT), "stray load")
  `PWMR_ASSERT(a_active_off_goal, active_r |-> (level_now_r != goal_r), "active ramp sits on goal")
  `PWMR_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid_r, "output not empty after reset")

endmodule
`default_nettype wire
